/* design/ueh_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and entity tables for the UTF-8 HTML escaper.
// Used by ueh_ctrl, ueh_datapath and utf8_html_entity_escaper. No dependencies.
package ueh_pkg;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 21;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 7;
    localparam int QUO_W      = 18;
    localparam int ENT_POS_W  = 3;

    // Divide by ten: q = (v * RECIP_10) >> RECIP_SHIFT, exact for v < 2^21
    localparam logic [19:0] RECIP_10    = 20'hCCCCD;
    localparam int          RECIP_SHIFT = 23;

    // Fixed output characters
    localparam logic [BYTE_W-1:0] CHR_AMP  = 8'h26;
    localparam logic [BYTE_W-1:0] CHR_HASH = 8'h23;
    localparam logic [BYTE_W-1:0] CHR_SEMI = 8'h3B;
    localparam logic [BYTE_W-1:0] CHR_ZERO = 8'h30;

    // Transfer payloads
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              line_end;
    } ueh_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_char;
        logic              run_last;
    } ueh_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PASS,
        S_ENT,
        S_DIV,
        S_AMP,
        S_HASH,
        S_DIG,
        S_SEMI
    } ueh_state_t;

    // What one input byte turns into
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_PASS,
        CLS_ENT,
        CLS_NUM_BYTE,
        CLS_NUM_ACCUM,
        CLS_BROKEN
    } ueh_cls_t;

    // Source of the value fed to the decimal converter
    typedef enum logic [1:0] {
        SRC_BYTE,
        SRC_ACCUM,
        SRC_HELD
    } ueh_src_t;

    // Output character select
    typedef enum logic [2:0] {
        CH_BYTE,
        CH_ENT,
        CH_AMP,
        CH_HASH,
        CH_DIGIT,
        CH_SEMI
    } ueh_chsel_t;

    typedef enum logic [1:0] {
        ENT_LT,
        ENT_GT,
        ENT_AMP,
        ENT_QUOT
    } ueh_ent_t;

    // Controller to datapath
    typedef struct packed {
        logic       capture;
        logic       update;
        logic       emit;
        ueh_chsel_t chsel;
        logic       last;
        logic       ent_start;
        logic       num_load;
        ueh_src_t   src;
        logic       replay_start;
        logic       replay_next;
        logic       div_step;
    } ueh_cmd_t;

    // Datapath to controller
    typedef struct packed {
        ueh_cls_t cls;
        logic     out_free;
        logic     ent_last;
        logic     div_last;
        logic     dig_last;
        logic     held_more;
    } ueh_status_t;

    // Named entity text, one character per position
    function automatic logic [BYTE_W-1:0] ent_char(ueh_ent_t k, logic [ENT_POS_W-1:0] pos);
        logic [BYTE_W-1:0] ch;
        ch = CHR_SEMI;
        case (k)
            ENT_LT:
            begin
                case (pos)
                    3'd0:    ch = CHR_AMP;
                    3'd1:    ch = "l";
                    3'd2:    ch = "t";
                    default: ch = CHR_SEMI;
                endcase
            end
            ENT_GT:
            begin
                case (pos)
                    3'd0:    ch = CHR_AMP;
                    3'd1:    ch = "g";
                    3'd2:    ch = "t";
                    default: ch = CHR_SEMI;
                endcase
            end
            ENT_AMP:
            begin
                case (pos)
                    3'd0:    ch = CHR_AMP;
                    3'd1:    ch = "a";
                    3'd2:    ch = "m";
                    3'd3:    ch = "p";
                    default: ch = CHR_SEMI;
                endcase
            end
            ENT_QUOT:
            begin
                case (pos)
                    3'd0:    ch = CHR_AMP;
                    3'd1:    ch = "q";
                    3'd2:    ch = "u";
                    3'd3:    ch = "o";
                    3'd4:    ch = "t";
                    default: ch = CHR_SEMI;
                endcase
            end
            default: ch = CHR_SEMI;
        endcase
        return ch;
    endfunction

    // Position of the closing semicolon
    function automatic logic [ENT_POS_W-1:0] ent_end(ueh_ent_t k);
        logic [ENT_POS_W-1:0] p;
        case (k)
            ENT_LT:   p = 3'd3;
            ENT_GT:   p = 3'd3;
            ENT_AMP:  p = 3'd4;
            ENT_QUOT: p = 3'd5;
            default:  p = 3'd5;
        endcase
        return p;
    endfunction

endpackage

/* design/utf8_html_entity_escaper.sv */
`timescale 1ns / 1ps
// UTF-8 to HTML escaper: one byte in, a run of escaped ASCII characters out, with
// reset of run_last on every character but the last of each run. One byte is
// taken at a time; the next is taken only once the previous byte's run has been
// handed to the output register, which holds one character and holds up the run
// while it is full and the consumer stalls. A byte is captured, then decoded; a
// byte that yields no character ends there, and one plain character is loaded at
// decode if the output is free. A named entity is emitted character by character.
// A decimal reference &#N; first runs the shared divide-by-ten unit (a reciprocal
// multiply) once per digit, then emits its characters; a broken multi-byte sequence
// runs that unit once for each held byte and once for the breaking byte. There is
// no clearing pass after reset.
// Depends on ueh_pkg, ueh_ctrl and ueh_datapath.
module utf8_html_entity_escaper (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  ueh_pkg::ueh_in_t  byte_item,
    output logic              char_valid,
    input  logic              char_stall,
    output ueh_pkg::ueh_out_t char_item
);
    import ueh_pkg::*;

    ueh_cmd_t    cmd;
    ueh_status_t status;

    ueh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .status     (status),
        .cmd        (cmd)
    );

    ueh_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_item  (byte_item),
        .char_stall (char_stall),
        .cmd        (cmd),
        .status     (status),
        .char_valid (char_valid),
        .char_item  (char_item)
    );

`ifndef SYNTHESIS
    // A character is only loaded when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("character loaded over a waiting transfer");

    // After a byte is captured the input stalls while it is decoded
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> byte_stall)
        else $error("input not stalled after capture");

    // The last character of a run frees the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> !byte_stall)
        else $error("input still stalled after end of run");

    // Digits are only emitted while the converter holds some
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.chsel == CH_DIGIT) |-> !$past(cmd.num_load))
        else $error("digit emitted straight after converter load");
`endif

endmodule

/* design/ueh_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing controller for the escaper: steps each byte through decode and emission.
// Depends on ueh_pkg; drives the command struct of ueh_datapath.
module ueh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  ueh_pkg::ueh_status_t status,
    output ueh_pkg::ueh_cmd_t    cmd
);
    import ueh_pkg::*;

    ueh_state_t state_reg, state_next;
    logic       replay_reg, replay_next;

    // State and replay flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            replay_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            replay_reg <= replay_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        replay_next = replay_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (byte_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                replay_next = (status.cls == CLS_BROKEN);
                case (status.cls)
                    CLS_NONE:      state_next = S_IDLE;
                    CLS_PASS:      state_next = status.out_free ? S_IDLE : S_PASS;
                    CLS_ENT:       state_next = S_ENT;
                    CLS_NUM_BYTE:  state_next = S_DIV;
                    CLS_NUM_ACCUM: state_next = S_DIV;
                    CLS_BROKEN:    state_next = S_DIV;
                    default:       state_next = S_IDLE;
                endcase
            end
            S_PASS:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            S_ENT:
            begin
                if (status.out_free && status.ent_last)
                    state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (status.div_last)
                    state_next = S_AMP;
            end
            S_AMP:
            begin
                if (status.out_free)
                    state_next = S_HASH;
            end
            S_HASH:
            begin
                if (status.out_free)
                    state_next = S_DIG;
            end
            S_DIG:
            begin
                if (status.out_free && status.dig_last)
                    state_next = S_SEMI;
            end
            S_SEMI:
            begin
                if (status.out_free)
                begin
                    state_next = replay_reg ? S_DIV : S_IDLE;
                    if (replay_reg && !status.held_more)
                        replay_next = 1'b0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd        = '0;
        byte_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = byte_valid;
            end
            S_DECODE:
            begin
                cmd.update = 1'b1;
                case (status.cls)
                    CLS_PASS:
                    begin
                        cmd.emit  = status.out_free;
                        cmd.chsel = CH_BYTE;
                        cmd.last  = 1'b1;
                    end
                    CLS_ENT:
                    begin
                        cmd.ent_start = 1'b1;
                    end
                    CLS_NUM_BYTE:
                    begin
                        cmd.num_load = 1'b1;
                        cmd.src      = SRC_BYTE;
                    end
                    CLS_NUM_ACCUM:
                    begin
                        cmd.num_load = 1'b1;
                        cmd.src      = SRC_ACCUM;
                    end
                    CLS_BROKEN:
                    begin
                        cmd.num_load     = 1'b1;
                        cmd.src          = SRC_HELD;
                        cmd.replay_start = 1'b1;
                    end
                    default: cmd.update = 1'b1;
                endcase
            end
            S_PASS:
            begin
                cmd.emit  = status.out_free;
                cmd.chsel = CH_BYTE;
                cmd.last  = 1'b1;
            end
            S_ENT:
            begin
                cmd.emit  = status.out_free;
                cmd.chsel = CH_ENT;
                cmd.last  = status.ent_last;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_AMP:
            begin
                cmd.emit  = status.out_free;
                cmd.chsel = CH_AMP;
            end
            S_HASH:
            begin
                cmd.emit  = status.out_free;
                cmd.chsel = CH_HASH;
            end
            S_DIG:
            begin
                cmd.emit  = status.out_free;
                cmd.chsel = CH_DIGIT;
            end
            S_SEMI:
            begin
                cmd.emit  = status.out_free;
                cmd.chsel = CH_SEMI;
                cmd.last  = !replay_reg;
                // replay of a broken sequence: next held byte, then the breaking byte
                if (replay_reg && status.out_free)
                begin
                    cmd.num_load    = 1'b1;
                    cmd.src         = status.held_more ? SRC_HELD : SRC_BYTE;
                    cmd.replay_next = status.held_more;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

/* design/ueh_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the escaper: UTF-8 decoder state, held bytes, decimal converter,
// entity text and the output register. Depends on ueh_pkg; driven by ueh_ctrl.
module ueh_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ueh_pkg::ueh_in_t     byte_item,
    input  logic                 char_stall,
    input  ueh_pkg::ueh_cmd_t    cmd,
    output ueh_pkg::ueh_status_t status,
    output logic                 char_valid,
    output ueh_pkg::ueh_out_t    char_item
);
    import ueh_pkg::*;

    // Captured input
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    // Decoder state
    logic              halted_reg, halted_next;
    logic [1:0]        be_reg, be_next;
    logic [CODE_W-1:0] acc_reg, acc_next;
    logic [1:0]        hc_reg, hc_next;
    logic [BYTE_W-1:0] held_reg [3];
    logic              held_we;
    logic [1:0]        held_wa;

    // Replay of held bytes
    logic [1:0]        replay_idx_reg, replay_idx_next;
    logic [1:0]        replay_cnt_reg;
    logic [BYTE_W-1:0] held_rd;

    // Entity emission
    logic [ENT_POS_W-1:0] ent_pos_reg;
    ueh_ent_t             ent_kind;
    logic                 is_ent;

    // Decimal converter
    logic [CODE_W-1:0]  num_reg;
    logic [CODE_W-1:0]  num_src;
    logic [2:0]         dig_cnt_reg;
    logic [DIGIT_W-1:0] dig_buf_reg [NUM_DIGITS];
    logic [40:0]        prod;
    logic [QUO_W-1:0]   quo;
    logic [CODE_W-1:0]  quo_x10;
    logic [CODE_W-1:0]  rem;
    logic [DIGIT_W-1:0] dig_rd;

    // Output register
    logic              out_valid_reg;
    ueh_out_t          out_reg;
    logic [BYTE_W-1:0] out_char;

    logic              is_cont;
    logic [CODE_W-1:0] acc_cont;
    logic              out_free;
    ueh_cls_t          cls;

    assign is_cont  = (byte_reg[7:6] == 2'b10);
    assign acc_cont = {acc_reg[CODE_W-7:0], byte_reg[5:0]};
    assign out_free = !out_valid_reg || !char_stall;

    // Named entity lookup
    always_comb
    begin
        is_ent   = 1'b1;
        ent_kind = ENT_LT;
        case (byte_reg)
            8'h3C:   ent_kind = ENT_LT;
            8'h3E:   ent_kind = ENT_GT;
            8'h26:   ent_kind = ENT_AMP;
            8'h22:   ent_kind = ENT_QUOT;
            default: is_ent   = 1'b0;
        endcase
    end

    // Classify the captured byte against the current decoder state
    always_comb
    begin
        cls = CLS_NONE;
        if (halted_reg || byte_reg == 8'h00)
            cls = CLS_NONE;
        else if (be_reg != 2'd0)
        begin
            if (!is_cont)
                cls = CLS_BROKEN;
            else if (be_reg == 2'd1)
                cls = CLS_NUM_ACCUM;
            else
                cls = CLS_NONE;
        end
        else if (byte_reg < 8'h80)
        begin
            if (is_ent)
                cls = CLS_ENT;
            else if (byte_reg == 8'h27)
                cls = CLS_NUM_BYTE;      // apostrophe: &#39;
            else if (byte_reg == 8'h0A || byte_reg == 8'h0B || byte_reg == 8'h0C ||
                     byte_reg == 8'h0D)
                cls = CLS_NONE;
            else if ((byte_reg >= 8'h20 && byte_reg <= 8'h7E) || byte_reg == 8'h09)
                cls = CLS_PASS;
            else
                cls = CLS_NUM_BYTE;
        end
        else if (byte_reg < 8'hC0 || byte_reg >= 8'hF8)
            cls = CLS_NUM_BYTE;          // stray continuation or bad lead
        else
            cls = CLS_NONE;              // lead byte
    end

    assign status.cls = cls;

    // Decoder state update
    always_comb
    begin
        halted_next = halted_reg;
        be_next     = be_reg;
        acc_next    = acc_reg;
        hc_next     = hc_reg;
        held_we     = 1'b0;
        held_wa     = hc_reg;
        if (cmd.update)
        begin
            if (!halted_reg)
            begin
                if (byte_reg == 8'h00)
                begin
                    be_next     = 2'd0;
                    acc_next    = '0;
                    hc_next     = 2'd0;
                    halted_next = 1'b1;
                end
                else if (be_reg != 2'd0)
                begin
                    if (is_cont)
                    begin
                        be_next = be_reg - 2'd1;
                        if (be_reg == 2'd1)
                        begin
                            acc_next = '0;
                            hc_next  = 2'd0;
                        end
                        else
                        begin
                            acc_next = acc_cont;
                            if (hc_reg != 2'd3)
                            begin
                                held_we = 1'b1;
                                hc_next = hc_reg + 2'd1;
                            end
                        end
                    end
                    else
                    begin
                        be_next  = 2'd0;
                        acc_next = '0;
                        hc_next  = 2'd0;
                    end
                end
                else if (byte_reg >= 8'hC0 && byte_reg < 8'hF8)
                begin
                    held_we = 1'b1;
                    held_wa = 2'd0;
                    hc_next = 2'd1;
                    if (byte_reg < 8'hE0)
                    begin
                        be_next  = 2'd1;
                        acc_next = {16'd0, byte_reg[4:0]};
                    end
                    else if (byte_reg < 8'hF0)
                    begin
                        be_next  = 2'd2;
                        acc_next = {17'd0, byte_reg[3:0]};
                    end
                    else
                    begin
                        be_next  = 2'd3;
                        acc_next = {18'd0, byte_reg[2:0]};
                    end
                end
            end
            // line end clears the decoder state
            if (last_reg)
            begin
                be_next     = 2'd0;
                acc_next    = '0;
                hc_next     = 2'd0;
                halted_next = 1'b0;
            end
        end
    end

    // Held byte read for replay
    always_comb
    begin
        replay_idx_next = replay_idx_reg;
        if (cmd.replay_start)
            replay_idx_next = 2'd0;
        else if (cmd.replay_next)
            replay_idx_next = replay_idx_reg + 2'd1;
    end

    assign held_rd          = held_reg[replay_idx_next];
    assign status.held_more = ({1'b0, replay_idx_reg} + 3'd1) < {1'b0, replay_cnt_reg};

    // Converter input select
    always_comb
    begin
        case (cmd.src)
            SRC_BYTE:  num_src = {13'd0, byte_reg};
            SRC_ACCUM: num_src = acc_cont;
            SRC_HELD:  num_src = {13'd0, held_rd};
            default:   num_src = '0;
        endcase
    end

    // One decimal digit per step via reciprocal multiply
    assign prod            = {20'd0, num_reg} * {21'd0, RECIP_10};
    assign quo             = QUO_W'(prod >> RECIP_SHIFT);
    assign quo_x10         = ({3'd0, quo} << 3) + ({3'd0, quo} << 1);
    assign rem             = num_reg - quo_x10;
    assign status.div_last = (quo == '0);
    assign dig_rd          = dig_buf_reg[dig_cnt_reg - 3'd1];
    assign status.dig_last = (dig_cnt_reg == 3'd1);

    assign status.ent_last = (ent_pos_reg == ent_end(ent_kind));
    assign status.out_free = out_free;

    // Output character select
    always_comb
    begin
        case (cmd.chsel)
            CH_BYTE:  out_char = byte_reg;
            CH_ENT:   out_char = ent_char(ent_kind, ent_pos_reg);
            CH_AMP:   out_char = CHR_AMP;
            CH_HASH:  out_char = CHR_HASH;
            CH_DIGIT: out_char = CHR_ZERO + {4'd0, dig_rd};
            CH_SEMI:  out_char = CHR_SEMI;
            default:  out_char = CHR_SEMI;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg     <= 1'b0;
            be_reg         <= 2'd0;
            acc_reg        <= '0;
            hc_reg         <= 2'd0;
            replay_idx_reg <= 2'd0;
            replay_cnt_reg <= 2'd0;
            ent_pos_reg    <= '0;
            dig_cnt_reg    <= 3'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            halted_reg     <= halted_next;
            be_reg         <= be_next;
            acc_reg        <= acc_next;
            hc_reg         <= hc_next;
            replay_idx_reg <= replay_idx_next;
            if (cmd.replay_start)
                replay_cnt_reg <= hc_reg;
            if (cmd.ent_start)
                ent_pos_reg <= '0;
            else if (cmd.emit && cmd.chsel == CH_ENT)
                ent_pos_reg <= ent_pos_reg + 3'd1;
            if (cmd.num_load)
                dig_cnt_reg <= 3'd0;
            else if (cmd.div_step)
                dig_cnt_reg <= dig_cnt_reg + 3'd1;
            else if (cmd.emit && cmd.chsel == CH_DIGIT)
                dig_cnt_reg <= dig_cnt_reg - 3'd1;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!char_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= byte_item.in_byte;
            last_reg <= byte_item.line_end;
        end
        if (held_we)
            held_reg[held_wa] <= byte_reg;
        if (cmd.num_load)
            num_reg <= num_src;
        else if (cmd.div_step)
        begin
            num_reg                  <= {3'd0, quo};
            dig_buf_reg[dig_cnt_reg] <= rem[DIGIT_W-1:0];
        end
        if (cmd.emit)
        begin
            out_reg.out_char <= out_char;
            out_reg.run_last <= cmd.last;
        end
    end

    assign char_valid = out_valid_reg;
    assign char_item  = out_reg;

endmodule

/* dv/ueh_escape_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the UTF-8 HTML escaper: predicts the escaped character run of every
// accepted input byte and compares each output transfer against it, in order.
// Depends on ueh_pkg for the transfer payload types.
module ueh_escape_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic              byte_stall,
    input  ueh_pkg::ueh_in_t  byte_item,
    input  logic              char_valid,
    input  logic              char_stall,
    input  ueh_pkg::ueh_out_t char_item,
    input  logic              flush_check,
    output int                mismatches,
    output int                pending,
    output int                chars_checked
);

    // Character codes with special handling
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_VT    = 8'h0B;
    localparam logic [7:0] CHR_FF    = 8'h0C;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TILDE = 8'h7E;

    // Lead byte boundaries
    localparam logic [7:0] LEAD3_MIN    = 8'hE0;
    localparam logic [7:0] LEAD4_MIN    = 8'hF0;
    localparam logic [7:0] LEAD2_MIN    = 8'hC0;
    localparam logic [7:0] BAD_LEAD_MIN = 8'hF8;

    localparam int MAX_REPORTS = 40;

    // Decoder state of the prediction
    logic [1:0]  cont_left;
    logic [20:0] code_point;
    logic [7:0]  held_seq [0:2];
    logic [1:0]  held_len;
    logic        line_halted;

    logic [7:0]        run_text [$];
    ueh_pkg::ueh_out_t expected_chars [$];

    task automatic report(input string what);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, what);
        mismatches++;
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            run_text.push_back(s[i]);
    endtask

    // &#N; with N in decimal, most significant digit first
    task automatic put_decimal(input logic [20:0] v);
        logic [7:0]  dig [0:7];
        logic [20:0] rest;
        int          k;
        put_text("&#");
        rest = v;
        k = 0;
        do
        begin
            dig[k] = 8'("0") + 8'(rest % 10);
            rest = rest / 10;
            k++;
        end
        while (rest != 0);
        while (k > 0)
        begin
            k--;
            run_text.push_back(dig[k]);
        end
        run_text.push_back(";");
    endtask

    task automatic put_ascii(input logic [7:0] c);
        case (c)
            "<":  put_text("&lt;");
            ">":  put_text("&gt;");
            "'":  put_text("&#39;");
            "&":  put_text("&amp;");
            "\"": put_text("&quot;");
            CHR_VT, CHR_FF, CHR_CR, CHR_LF:
            begin
                // dropped
            end
            default:
            begin
                if ((c >= CHR_SPACE && c <= CHR_TILDE) || c == CHR_TAB)
                    run_text.push_back(c);
                else
                    put_decimal({13'd0, c});
            end
        endcase
    endtask

    task automatic clear_sequence();
        cont_left  = 2'd0;
        code_point = 21'd0;
        held_len   = 2'd0;
    endtask

    // Works out the characters one input byte causes and queues them
    task automatic predict_escape(input logic [7:0] c, input logic line_end);
        ueh_pkg::ueh_out_t ch;
        int                i;
        run_text.delete();
        if (line_halted)
        begin
            // silent until the line ends
        end
        else if (c == CHR_NUL)
        begin
            clear_sequence();
            line_halted = 1'b1;
        end
        else if (cont_left != 2'd0)
        begin
            if (c[7:6] == 2'b10)
            begin
                code_point = {code_point[14:0], c[5:0]};
                cont_left  = cont_left - 2'd1;
                if (cont_left == 2'd0)
                begin
                    put_decimal(code_point);
                    held_len   = 2'd0;
                    code_point = 21'd0;
                end
                else if (held_len < 2'd3)
                begin
                    held_seq[held_len] = c;
                    held_len = held_len + 2'd1;
                end
            end
            else
            begin
                // broken sequence: replay the held bytes, then the breaking one
                for (i = 0; i < held_len; i++)
                    put_decimal({13'd0, held_seq[i]});
                put_decimal({13'd0, c});
                clear_sequence();
            end
        end
        else if (!c[7])
            put_ascii(c);
        else if (c < LEAD2_MIN || c >= BAD_LEAD_MIN)
            put_decimal({13'd0, c});
        else
        begin
            if (c < LEAD3_MIN)
            begin
                cont_left  = 2'd1;
                code_point = {16'd0, c[4:0]};
            end
            else if (c < LEAD4_MIN)
            begin
                cont_left  = 2'd2;
                code_point = {17'd0, c[3:0]};
            end
            else
            begin
                cont_left  = 2'd3;
                code_point = {18'd0, c[2:0]};
            end
            held_seq[0] = c;
            held_len    = 2'd1;
        end

        if (line_end)
        begin
            clear_sequence();
            line_halted = 1'b0;
        end

        for (i = 0; i < run_text.size(); i++)
        begin
            ch.out_char = run_text[i];
            ch.run_last = (i == run_text.size() - 1);
            expected_chars.push_back(ch);
        end
    endtask

    // Watch both channels; input side first so its run lands behind older ones
    always @(posedge clk)
    begin : watch
        ueh_pkg::ueh_out_t want;
        if (!rst_n)
        begin
            clear_sequence();
            line_halted = 1'b0;
            expected_chars.delete();
        end
        else
        begin
            if (byte_valid && !byte_stall)
                predict_escape(byte_item.in_byte, byte_item.line_end);

            if (char_valid && !char_stall)
            begin
                if (expected_chars.size() == 0)
                    report($sformatf("unexpected character 0x%02h run_last %0b",
                                     char_item.out_char, char_item.run_last));
                else
                begin
                    want = expected_chars.pop_front();
                    chars_checked++;
                    if (char_item.out_char !== want.out_char)
                        report($sformatf("out_char 0x%02h, expected 0x%02h",
                                         char_item.out_char, want.out_char));
                    if (char_item.run_last !== want.run_last)
                        report($sformatf("run_last %0b on 0x%02h, expected %0b",
                                         char_item.run_last, char_item.out_char,
                                         want.run_last));
                end
            end

            if (flush_check && expected_chars.size() != 0)
                report($sformatf("%0d expected characters never arrived",
                                 expected_chars.size()));
        end
        pending = expected_chars.size();
    end

endmodule

/* dv/utf8_html_entity_escaper_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the UTF-8 HTML escaper: drives byte lines with bursty timing,
// stalls the output side, and gives the verdict from the checker's mismatch count.
// Depends on ueh_pkg, ueh_escape_checker and utf8_html_entity_escaper.
module utf8_html_entity_escaper_tb;

    localparam int CLK_HALF        = 1;
    localparam int RANDOM_ITEMS    = 200;
    localparam int HOLD_OFF_AT     = 60;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_PAUSE_AT  = 140;
    localparam int TAIL_CYCLES     = 60;
    localparam int WATCHDOG_LIMIT  = 2000;

    localparam logic [7:0] CHR_NUL = 8'h00;
    localparam logic [7:0] CHR_TAB = 8'h09;
    localparam logic [7:0] CHR_LF  = 8'h0A;
    localparam logic [7:0] CHR_VT  = 8'h0B;
    localparam logic [7:0] CHR_FF  = 8'h0C;
    localparam logic [7:0] CHR_CR  = 8'h0D;
    localparam logic [7:0] CHR_US  = 8'h1F;
    localparam logic [7:0] CHR_DEL = 8'h7F;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_SQUARE
    } rx_mode_t;

    logic              clk;
    logic              rst_n;
    logic              byte_valid;
    logic              byte_stall;
    ueh_pkg::ueh_in_t  byte_item;
    logic              char_valid;
    logic              char_stall;
    ueh_pkg::ueh_out_t char_item;
    logic              flush_check;

    int mismatches;
    int pending;
    int chars_checked;
    int bytes_sent;
    int lines_built;
    int seqs_built;
    int breaks_built;
    int quiet_cycles;

    ueh_pkg::ueh_in_t line_bytes [$];

    utf8_html_entity_escaper i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

    ueh_escape_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_item     (byte_item),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .char_item     (char_item),
        .flush_check   (flush_check),
        .mismatches    (mismatches),
        .pending       (pending),
        .chars_checked (chars_checked)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    task automatic queue_byte(input logic [7:0] b);
        ueh_pkg::ueh_in_t item;
        item.in_byte  = b;
        item.line_end = 1'b0;
        line_bytes.push_back(item);
    endtask

    // Marks the most recent byte as the end of its line
    task automatic end_line();
        ueh_pkg::ueh_in_t item;
        item = line_bytes.pop_back();
        item.line_end = 1'b1;
        line_bytes.push_back(item);
        lines_built++;
    endtask

    function automatic logic [7:0] pick_special();
        logic [7:0] b;
        case ($urandom_range(0, 13))
            0:       b = "<";
            1:       b = ">";
            2:       b = "'";
            3:       b = "&";
            4:       b = "\"";
            5:       b = CHR_TAB;
            6:       b = CHR_VT;
            7:       b = CHR_FF;
            8:       b = CHR_CR;
            9:       b = CHR_LF;
            10:      b = CHR_US;
            11:      b = CHR_DEL;
            12:      b = 8'h01;
            default: b = CHR_NUL;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] lead_for(input int n_cont);
        logic [7:0] b;
        case (n_cont)
            1:       b = 8'($urandom_range(8'hC0, 8'hDF));
            2:       b = 8'($urandom_range(8'hE0, 8'hEF));
            default: b = 8'($urandom_range(8'hF0, 8'hF7));
        endcase
        return b;
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // One line of mostly well-formed text with some noise mixed in
    task automatic add_random_line();
        int units;
        int k;
        int kind;
        int n_cont;
        int keep;
        units = $urandom_range(1, 10);
        for (k = 0; k < units; k++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
                queue_byte(8'($urandom_range(8'h20, 8'h7E)));
            else if (kind < 52)
                queue_byte(pick_special());
            else if (kind < 80)
            begin
                n_cont = $urandom_range(1, 3);
                queue_byte(lead_for(n_cont));
                repeat (n_cont) queue_byte(cont_byte());
                seqs_built++;
            end
            else if (kind < 90)
            begin
                // sequence cut short by a byte that is not a continuation
                n_cont = $urandom_range(1, 3);
                keep   = $urandom_range(0, n_cont - 1);
                queue_byte(lead_for(n_cont));
                repeat (keep) queue_byte(cont_byte());
                if ($urandom_range(0, 1) != 0)
                    queue_byte(8'($urandom_range(0, 8'h7F)));
                else
                    queue_byte(8'($urandom_range(8'hC0, 8'hFF)));
                breaks_built++;
            end
            else if (kind < 95)
            begin
                // truncated sequence, left hanging or broken by the next unit
                n_cont = $urandom_range(1, 3);
                keep   = $urandom_range(0, n_cont - 1);
                queue_byte(lead_for(n_cont));
                repeat (keep) queue_byte(cont_byte());
            end
            else
                queue_byte(8'($urandom_range(0, 255)));
        end
        end_line();
    endtask

    // Holds the transfer until the block takes it
    task automatic offer_byte(input ueh_pkg::ueh_in_t item);
        byte_valid <= 1'b1;
        byte_item  <= item;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
    endtask

    // Stall-free watchdog: any transfer on either side resets it
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (char_valid && !char_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles, %0d characters outstanding",
                     quiet_cycles, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // Output side: changing stall patterns plus one long hold-off
    initial
    begin : receiver
        rx_mode_t stall_mode;
        int       phase_cycles;
        logic     hold_off_done;
        char_stall   <= 1'b0;
        stall_mode    = RX_FREE;
        phase_cycles  = 0;
        hold_off_done = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (!hold_off_done && bytes_sent >= HOLD_OFF_AT)
            begin
                // block fills up and must stall its input
                char_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                char_stall   <= 1'b0;
                hold_off_done = 1'b1;
            end
            else
            begin
                if (phase_cycles == 0)
                begin
                    stall_mode   = rx_mode_t'($urandom_range(0, 3));
                    phase_cycles = $urandom_range(20, 80);
                end
                phase_cycles--;
                case (stall_mode)
                    RX_FREE:  char_stall <= 1'b0;
                    RX_LIGHT: char_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: char_stall <= ($urandom_range(0, 3) != 0);
                    default:  char_stall <= phase_cycles[2];
                endcase
            end
        end
    end

    // Input side: directed line, random lines, verdict
    initial
    begin : sender
        int idx;
        int burst;
        int gap;
        int directed_count;

        rst_n       <= 1'b0;
        byte_valid  <= 1'b0;
        byte_item   <= '0;
        flush_check <= 1'b0;
        bytes_sent   = 0;
        lines_built  = 0;
        seqs_built   = 0;
        breaks_built = 0;

        // Entities, dropped and numbered controls
        queue_byte("<");
        queue_byte(">");
        queue_byte("'");
        queue_byte("&");
        queue_byte("\"");
        queue_byte(CHR_TAB);
        queue_byte(CHR_VT);
        queue_byte(CHR_FF);
        queue_byte(CHR_CR);
        queue_byte(CHR_LF);
        queue_byte(8'h01);
        queue_byte(CHR_DEL);
        // stray continuation byte and bad lead byte
        queue_byte(8'h80);
        queue_byte(8'hFF);
        // two-byte and largest four-byte code points
        queue_byte(8'hC3);
        queue_byte(8'hA9);
        queue_byte(8'hF7);
        queue_byte(8'hBF);
        queue_byte(8'hBF);
        queue_byte(8'hBF);
        // broken four-byte sequence giving the longest run, then NUL silences the rest of the line
        queue_byte(8'hF0);
        queue_byte(8'h9F);
        queue_byte(8'h98);
        queue_byte(8'hC3);
        queue_byte(CHR_NUL);
        queue_byte("<");
        end_line();
        // incomplete sequence at line end is dropped
        queue_byte(8'hE2);
        queue_byte(8'h82);
        end_line();
        directed_count = line_bytes.size();

        while (line_bytes.size() < directed_count + RANDOM_ITEMS)
            add_random_line();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idx = 0;
        while (idx < line_bytes.size())
        begin
            if ($urandom_range(0, 3) == 0)
                burst = $urandom_range(20, 60);
            else
                burst = $urandom_range(1, 8);
            while (burst > 0 && idx < line_bytes.size())
            begin
                offer_byte(line_bytes[idx]);
                idx++;
                burst--;
                bytes_sent++;
                if (idx == DRAIN_PAUSE_AT)
                begin
                    // wait for the output to catch up completely
                    byte_valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
            end
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        byte_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        flush_check <= 1'b1;
        @(posedge clk);
        flush_check <= 1'b0;
        @(posedge clk);

        $display("Escaped %0d bytes over %0d lines: %0d UTF-8 sequences, %0d broken ones",
                 bytes_sent, lines_built, seqs_built, breaks_built);
        $display("Checked %0d output characters, %0d mismatches", chars_checked, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
